/* hw/rtl/mbsp_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Shared item types, parser state, state codes and the data count function.
// ----------------------------------------------------------------------------
package mbsp_pkg;

	// Status byte codes with a special meaning.
	localparam logic [7:0] SYSEX_START = 8'hF0;
	localparam logic [7:0] SYSEX_END   = 8'hF7;
	localparam logic [7:0] HIGH_NIBBLE = 8'hF0;
	localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
	localparam logic [7:0] STATUS_C0   = 8'hC0;
	localparam logic [7:0] STATUS_D0   = 8'hD0;
	localparam logic [7:0] STATUS_F1   = 8'hF1;
	localparam logic [7:0] STATUS_F2   = 8'hF2;
	localparam logic [7:0] STATUS_F3   = 8'hF3;
	localparam logic [15:0] TALLY_MAX  = 16'hFFFF;

	// Parser states, one-hot.
	typedef enum logic [3:0] {
		ST_STATUS      = 4'b0001,
		ST_DATA        = 4'b0010,
		ST_STATUS_DATA = 4'b0100,
		ST_SYSEX       = 4'b1000
	} parse_state_t;

	// One input item.
	typedef struct packed {
		logic [7:0]  byte_in;
		logic [31:0] time_stamp;
	} byte_item_t;

	// One result item.
	typedef struct packed {
		logic        kind;
		logic [7:0]  msg_status;
		logic [3:0]  channel;
		logic [6:0]  first_data;
		logic [6:0]  second_data;
		logic [7:0]  sysex_byte;
		logic        sysex_last;
		logic [31:0] stamp_out;
		logic [15:0] errors_seen;
	} msg_item_t;

	// Everything the parser carries from one item to the next.
	typedef struct packed {
		parse_state_t parse_state;
		logic [7:0]   running_status;
		logic [6:0]   held_data;
		logic [1:0]   needed_data;
		logic         data_position;
		logic [15:0]  error_tally;
	} parse_regs_t;

	// Number of data bytes that follow a status byte.
	function automatic logic [1:0] data_count(input logic [7:0] st);
		logic [1:0] n;
		n = 2'd0;
		if (st < SYSEX_START) begin
			if ((st & HIGH_NIBBLE) == STATUS_C0 || (st & HIGH_NIBBLE) == STATUS_D0) begin
				n = 2'd1;
			end else begin
				n = 2'd2;
			end
		end else if (st == STATUS_F1 || st == STATUS_F3) begin
			n = 2'd1;
		end else if (st == STATUS_F2) begin
			n = 2'd2;
		end
		return n;
	endfunction

endpackage

/* hw/rtl/mbsp_step.sv */
// ----------------------------------------------------------------------------
// MIDI parser step
// Next parser state and the optional result item for one received byte.
// ----------------------------------------------------------------------------
module mbsp_step (
	input  mbsp_pkg::parse_regs_t cur,
	input  mbsp_pkg::byte_item_t  item,
	output mbsp_pkg::parse_regs_t nxt,
	output logic                  res_valid,
	output mbsp_pkg::msg_item_t   res
);

	logic [7:0]  b;
	logic [15:0] tally_inc;
	logic [7:0]  msg_st;
	logic        is_chan;
	logic [6:0]  d0;
	logic [6:0]  d1;
	logic        want_msg;
	logic        want_sysex;
	logic        sysex_last;

	assign b = item.byte_in;

	// Saturating increment of the error count.
	assign tally_inc = cur.error_tally + ((cur.error_tally != mbsp_pkg::TALLY_MAX) ? 16'd1 : 16'd0);

	// State transition for the byte.
	always_comb begin
		nxt        = cur;
		want_msg   = 1'b0;
		want_sysex = 1'b0;
		sysex_last = 1'b0;
		d0         = 7'd0;
		d1         = 7'd0;
		if (b[7]) begin
			if (b == mbsp_pkg::SYSEX_END) begin
				if (cur.parse_state == mbsp_pkg::ST_SYSEX) begin
					nxt.parse_state = mbsp_pkg::ST_STATUS;
					want_sysex      = 1'b1;
					sysex_last      = 1'b1;
				end else begin
					nxt.error_tally   = tally_inc;
					nxt.parse_state   = mbsp_pkg::ST_STATUS;
					nxt.data_position = 1'b0;
				end
			end else begin
				if (cur.parse_state == mbsp_pkg::ST_DATA ||
				    cur.parse_state == mbsp_pkg::ST_SYSEX) begin
					nxt.error_tally = tally_inc;
				end
				nxt.running_status = b;
				nxt.data_position  = 1'b0;
				if (b == mbsp_pkg::SYSEX_START) begin
					nxt.needed_data = 2'd0;
					nxt.parse_state = mbsp_pkg::ST_SYSEX;
					want_sysex      = 1'b1;
				end else begin
					nxt.needed_data = mbsp_pkg::data_count(b);
					if (nxt.needed_data != 2'd0) begin
						nxt.parse_state = mbsp_pkg::ST_DATA;
					end else begin
						nxt.parse_state = mbsp_pkg::ST_STATUS;
						want_msg        = 1'b1;
					end
				end
			end
		end else begin
			case (cur.parse_state)
				mbsp_pkg::ST_SYSEX: begin
					want_sysex = 1'b1;
				end
				mbsp_pkg::ST_DATA, mbsp_pkg::ST_STATUS_DATA: begin
					if (!cur.data_position) begin
						if (cur.needed_data == 2'd1) begin
							nxt.parse_state = (cur.running_status >= mbsp_pkg::SYSEX_START) ?
								mbsp_pkg::ST_STATUS : mbsp_pkg::ST_STATUS_DATA;
							want_msg = 1'b1;
							d0       = b[6:0];
						end else if (cur.needed_data == 2'd2) begin
							nxt.held_data     = b[6:0];
							nxt.data_position = 1'b1;
							nxt.parse_state   = mbsp_pkg::ST_DATA;
						end
					end else if (cur.needed_data == 2'd2) begin
						nxt.data_position = 1'b0;
						nxt.parse_state   = (cur.running_status >= mbsp_pkg::SYSEX_START) ?
							mbsp_pkg::ST_STATUS : mbsp_pkg::ST_STATUS_DATA;
						want_msg = 1'b1;
						d0       = cur.held_data;
						d1       = b[6:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result formatting, taken from the updated running status and count.
	assign msg_st  = nxt.running_status;
	assign is_chan = msg_st[7] && (msg_st < mbsp_pkg::SYSEX_START);

	always_comb begin
		res             = '0;
		res.stamp_out   = item.time_stamp;
		res.errors_seen = nxt.error_tally;
		if (want_sysex) begin
			res.kind       = 1'b1;
			res.sysex_byte = b;
			res.sysex_last = sysex_last;
		end else begin
			res.kind        = 1'b0;
			res.msg_status  = is_chan ? (msg_st & mbsp_pkg::HIGH_NIBBLE) : msg_st;
			res.channel     = is_chan ? msg_st[3:0] : 4'd0;
			res.first_data  = d0;
			res.second_data = d1;
		end
	end

	assign res_valid = want_msg || want_sysex;

endmodule

/* hw/rtl/midi_byte_stream_parser.sv */
// ----------------------------------------------------------------------------
// MIDI byte stream parser
// Running status parser that turns received bytes into messages and
// system-exclusive pass-through items.
//
//   Channel   Dir  Payload      Handshake
//   byte_*    in   byte_item_t  byte_valid / byte_stall
//   msg_*     out  msg_item_t   msg_valid  / msg_stall
//
// A byte is parsed from the input register once it is accepted, and its result,
// if any, is registered in the output register and offered on msg_* from there.
// One item is accepted every cycle while the output side keeps up.
// Reset puts the parser in the expect-status state with zero error count.
// A stalled output holds its item and the parser state; the input stalls once
// its register also holds a byte, whether or not that byte gives a result.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  mbsp_pkg::byte_item_t byte_item,
	output logic                 msg_valid,
	input  logic                 msg_stall,
	output mbsp_pkg::msg_item_t  msg_item
);

	logic                  valid_s1;
	mbsp_pkg::byte_item_t  item_s1;
	mbsp_pkg::parse_regs_t regs_q;
	mbsp_pkg::parse_regs_t regs_nxt;
	logic                  res_valid;
	mbsp_pkg::msg_item_t   res;
	logic                  out_valid_q;
	mbsp_pkg::msg_item_t   out_item_q;
	logic                  advance;

	// The held item moves on when the output register is free or emptying.
	assign advance    = valid_s1 && (!out_valid_q || !msg_stall);
	assign byte_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	mbsp_step u_step (
		.cur       (regs_q),
		.item      (item_s1),
		.nxt       (regs_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// Parser state advances once per parsed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.parse_state    <= mbsp_pkg::ST_STATUS;
			regs_q.running_status <= 8'd0;
			regs_q.held_data      <= 7'd0;
			regs_q.needed_data    <= 2'd0;
			regs_q.data_position  <= 1'b0;
			regs_q.error_tally    <= 16'd0;
		end else if (advance) begin
			regs_q <= regs_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (!msg_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_item_q <= res;
		end
	end

	assign msg_valid = out_valid_q;
	assign msg_item  = out_item_q;

	// The input side only stalls while it holds an item.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	// A held item leaves the parser state untouched.
	a_hold_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> $stable(regs_q))
		else $error("parser state changed while the item was held");

	// The error count never goes down.
	a_tally_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> regs_q.error_tally >= $past(regs_q.error_tally))
		else $error("error count decreased");

	// A closing system-exclusive byte returns the parser to expect a status.
	a_sysex_close: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && res.sysex_last) |=>
		regs_q.parse_state == mbsp_pkg::ST_STATUS)
		else $error("parser not in status state after closing byte");

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// MIDI byte stream parser testbench
// Drives received bytes with time stamps into the parser, predicts every
// message and system-exclusive item from its own copy of the parse state,
// and checks each result in order. Runs a directed opening, then random
// message streams under several idling patterns and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import mbsp_pkg::*;

	// Status bytes used by the stimulus that the package does not name.
	localparam logic [7:0] NOTE_OFF       = 8'h80;
	localparam logic [7:0] NOTE_ON        = 8'h90;
	localparam logic [7:0] CONTROL_CHANGE = 8'hB0;
	localparam logic [7:0] PITCH_BEND     = 8'hE0;
	localparam logic [7:0] TUNE_REQUEST   = 8'hF6;
	localparam logic [7:0] SYSTEM_RESET   = 8'hFF;

	localparam int HOLD_CYCLES  = 200;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 300;

	// Number of data bytes that a status byte calls for.
	function automatic logic [1:0] data_bytes_for(logic [7:0] st);
		if (st < SYSEX_START) begin
			return (st[7:4] == STATUS_C0[7:4] || st[7:4] == STATUS_D0[7:4]) ? 2'd1 : 2'd2;
		end
		if (st == STATUS_F1 || st == STATUS_F3) begin
			return 2'd1;
		end
		if (st == STATUS_F2) begin
			return 2'd2;
		end
		return 2'd0;
	endfunction

	// Parser prediction and in-order result checking.
	class midi_msg_scoreboard;
		parse_state_t state;
		logic [7:0]   run_status;
		logic [6:0]   held;
		logic [1:0]   need;
		logic         position;
		logic [15:0]  tally;
		msg_item_t    pending_msgs[$];
		int           failures;

		function new();
			state = ST_STATUS;
			run_status = '0;
			held = '0;
			need = '0;
			position = 1'b0;
			tally = '0;
			failures = 0;
		endfunction

		function void bump_tally();
			if (tally != TALLY_MAX) begin
				tally++;
			end
		endfunction

		function msg_item_t build_message(logic [6:0] d0, logic [6:0] d1);
			msg_item_t m;
			m = '0;
			if (run_status < SYSEX_START) begin
				m.msg_status = run_status & HIGH_NIBBLE;
				m.channel = run_status[3:0];
			end else begin
				m.msg_status = run_status;
			end
			m.first_data = d0;
			m.second_data = d1;
			return m;
		endfunction

		// Advances the parse state by one accepted item. Returns 0 when the
		// item is a stray data byte that the parser ignores.
		function bit take_byte(byte_item_t it);
			logic [7:0] b;
			msg_item_t  m;
			bit         emit;
			bit         useful;
			b = it.byte_in;
			m = '0;
			emit = 1'b0;
			useful = 1'b1;
			if (b[7]) begin
				if (b == SYSEX_END) begin
					if (state == ST_SYSEX) begin
						state = ST_STATUS;
						m.kind = 1'b1;
						m.sysex_byte = b;
						m.sysex_last = 1'b1;
						emit = 1'b1;
					end else begin
						bump_tally();
						state = ST_STATUS;
						position = 1'b0;
					end
				end else begin
					// A new status drops any unfinished message.
					if (state == ST_DATA || state == ST_SYSEX) begin
						bump_tally();
					end
					run_status = b;
					position = 1'b0;
					if (b == SYSEX_START) begin
						need = 2'd0;
						state = ST_SYSEX;
						m.kind = 1'b1;
						m.sysex_byte = b;
						emit = 1'b1;
					end else begin
						need = data_bytes_for(b);
						if (need != 2'd0) begin
							state = ST_DATA;
						end else begin
							state = ST_STATUS;
							m = build_message('0, '0);
							emit = 1'b1;
						end
					end
				end
			end else begin
				case (state)
					ST_SYSEX: begin
						m.kind = 1'b1;
						m.sysex_byte = b;
						emit = 1'b1;
					end
					ST_DATA, ST_STATUS_DATA: begin
						if (!position) begin
							if (need == 2'd1) begin
								state = (run_status >= SYSEX_START) ? ST_STATUS : ST_STATUS_DATA;
								m = build_message(b[6:0], '0);
								emit = 1'b1;
							end else if (need == 2'd2) begin
								held = b[6:0];
								position = 1'b1;
								state = ST_DATA;
							end
						end else if (need == 2'd2) begin
							position = 1'b0;
							state = (run_status >= SYSEX_START) ? ST_STATUS : ST_STATUS_DATA;
							m = build_message(held, b[6:0]);
							emit = 1'b1;
						end
					end
					default: begin
						useful = 1'b0;
					end
				endcase
			end
			if (emit) begin
				m.stamp_out = it.time_stamp;
				m.errors_seen = tally;
				pending_msgs.push_back(m);
			end
			return useful;
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				failures++;
			end
		endfunction

		function void check_msg(msg_item_t got);
			msg_item_t want;
			if (pending_msgs.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0h", $time, got);
				failures++;
				return;
			end
			want = pending_msgs.pop_front();
			check_field("kind", 32'(want.kind), 32'(got.kind));
			check_field("msg_status", 32'(want.msg_status), 32'(got.msg_status));
			check_field("channel", 32'(want.channel), 32'(got.channel));
			check_field("first_data", 32'(want.first_data), 32'(got.first_data));
			check_field("second_data", 32'(want.second_data), 32'(got.second_data));
			check_field("sysex_byte", 32'(want.sysex_byte), 32'(got.sysex_byte));
			check_field("sysex_last", 32'(want.sysex_last), 32'(got.sysex_last));
			check_field("stamp_out", want.stamp_out, got.stamp_out);
			check_field("errors_seen", 32'(want.errors_seen), 32'(got.errors_seen));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	byte_item_t byte_item = '0;
	logic       msg_valid;
	logic       msg_stall = 1'b0;
	msg_item_t  msg_item;

	logic       hold_request = 1'b0;
	int         send_idle_pct = 0;
	int         stall_pct = 0;
	int         useful_bytes = 0;
	int         quiet_cycles = 0;
	midi_msg_scoreboard sb;

	// Opening stream: stray data and stray end at reset, running status,
	// extreme data and stamps, system messages, a closed system-exclusive
	// block, then a status inside a message and a status inside sysex.
	logic [7:0] opening [30] = '{
		8'h00, SYSEX_END, NOTE_ON, 8'h3C, 8'h7F, 8'h00, 8'h00,
		PITCH_BEND | 8'h0F, 8'h7F, 8'h00, STATUS_C0 | 8'h05, 8'h12, 8'h34,
		STATUS_F2, 8'h7F, 8'h7F, STATUS_F1, 8'h05, SYSTEM_RESET,
		SYSEX_START, 8'h00, 8'h7F, SYSEX_END,
		NOTE_OFF, 8'h40, SYSEX_START, 8'h11, CONTROL_CHANGE | 8'h01, 8'h22, 8'h33
	};

	midi_byte_stream_parser DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.msg_valid  (msg_valid),
		.msg_stall  (msg_stall),
		.msg_item   (msg_item)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Offers one item, with random idle cycles ahead of it, and waits until it is taken.
	task automatic send_byte(input logic [7:0] b, input logic [31:0] stamp);
		byte_item_t it;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		it.byte_in = b;
		it.time_stamp = stamp;
		byte_valid <= 1'b1;
		byte_item <= it;
		@(posedge clk);
		while (byte_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic send_data(input int count);
		for (int k = 0; k < count; k++) begin
			send_byte({1'b0, 7'($urandom)}, $urandom());
		end
	endtask

	// One random group: mostly well-formed messages, some broken ones and noise.
	task automatic send_random_group();
		int         pick;
		int         reps;
		logic [7:0] st;
		pick = $urandom_range(99);
		st = {1'b1, 3'($urandom_range(6)), 4'($urandom)};
		if (pick < 40) begin
			// Channel message followed by running-status repeats.
			send_byte(st, $urandom());
			reps = $urandom_range(1, 4);
			for (int r = 0; r < reps; r++) begin
				send_data(int'(data_bytes_for(st)));
			end
		end else if (pick < 52) begin
			case ($urandom_range(2))
				0: st = STATUS_F1;
				1: st = STATUS_F2;
				default: st = STATUS_F3;
			endcase
			send_byte(st, $urandom());
			send_data(int'(data_bytes_for(st)));
		end else if (pick < 62) begin
			// Single-byte system and real-time messages.
			st = {4'hF, 4'($urandom_range(4, 15))};
			if (st == SYSEX_END) begin
				st = TUNE_REQUEST;
			end
			send_byte(st, $urandom());
		end else if (pick < 78) begin
			// System-exclusive block, occasionally left open.
			send_byte(SYSEX_START, $urandom());
			send_data($urandom_range(0, 12));
			if ($urandom_range(9) != 0) begin
				send_byte(SYSEX_END, $urandom());
			end
		end else if (pick < 90) begin
			// Message cut short; the next status lands in the middle of it.
			send_byte(st, $urandom());
			send_data(int'(data_bytes_for(st)) - 1);
		end else begin
			reps = $urandom_range(1, 4);
			for (int r = 0; r < reps; r++) begin
				send_byte(8'($urandom), $urandom());
			end
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stalls);
		int goal;
		send_idle_pct = idle_pct;
		stall_pct = stalls;
		goal = useful_bytes + PHASE_ITEMS;
		while (useful_bytes < goal) begin
			send_random_group();
		end
	endtask

	// Output side: random stalls, or a long hold-off when one is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request <= 1'b0;
				msg_stall <= 1'b1;
				for (int k = 0; k < HOLD_CYCLES; k++) begin
					@(posedge clk);
				end
				msg_stall <= 1'b0;
			end else begin
				msg_stall <= (stall_pct > 0 && $urandom_range(99) < stall_pct);
			end
		end
	end

	// Monitors on both channels and the no-progress watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				if (sb.take_byte(byte_item)) begin
					useful_bytes++;
				end
			end
			if (msg_valid && !msg_stall) begin
				sb.check_msg(msg_item);
			end
			if ((byte_valid && !byte_stall) || (msg_valid && !msg_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[midi_byte_stream_parser] ERROR");
				$finish;
			end
		end
	end

	// Main sequence.
	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) begin
			send_byte(opening[i], (i == 0) ? 32'h0 : (i == 4) ? 32'hFFFF_FFFF : $urandom());
		end

		// Back-to-back items while the output is held off for a long stretch.
		hold_request <= 1'b1;
		run_phase(0, 0);
		run_phase(66, 0);
		run_phase(0, 66);
		run_phase(6, 6);
		byte_valid <= 1'b0;

		while (sb.pending_msgs.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.failures == 0 && sb.pending_msgs.size() == 0) begin
			$display("[midi_byte_stream_parser] OK");
		end else begin
			$display("[midi_byte_stream_parser] ERROR");
		end
		$finish;
	end

endmodule
